// ===== rtl/evrot_pkg.sv =====
// ----------------------------------------------------------------------------
// evrot_pkg
// Shared types, constants and the arctangent table for the Euler ZYX
// vector rotation unit.
// ----------------------------------------------------------------------------
package evrot_pkg;

  localparam int ANGLE_W = 17;
  localparam int FIELD_W = 24;
  localparam int ZW      = 33;

  localparam int TURN         = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  // round(pi * 2^30) / 18000 split into an integer part and a remainder.
  localparam int RAD_INT     = 187403;
  localparam int RAD_REM     = 5426;
  localparam int RECIP       = 3817748;
  localparam int RECIP_SHIFT = 36;

  localparam logic signed [ZW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam int ATAN_ENTRIES = 24;

  localparam int SAT_MAX = 8388607;
  localparam int SAT_MIN = -8388608;

  typedef struct packed {
    logic                      orient;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic        [FIELD_W-1:0] mag;
  } carry_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 33'sd843314856;
      1:  r = 33'sd497837829;
      2:  r = 33'sd263043836;
      3:  r = 33'sd133525158;
      4:  r = 33'sd67021686;
      5:  r = 33'sd33543515;
      6:  r = 33'sd16775850;
      7:  r = 33'sd8388437;
      8:  r = 33'sd4194282;
      9:  r = 33'sd2097149;
      10: r = 33'sd1048575;
      11: r = 33'sd524287;
      12: r = 33'sd262143;
      13: r = 33'sd131071;
      14: r = 33'sd65535;
      15: r = 33'sd32767;
      16: r = 33'sd16383;
      17: r = 33'sd8191;
      18: r = 33'sd4095;
      19: r = 33'sd2047;
      20: r = 33'sd1023;
      21: r = 33'sd511;
      22: r = 33'sd255;
      23: r = 33'sd127;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/evrot_angle.sv =====
// ----------------------------------------------------------------------------
// evrot_angle
// Reduces three angles to a half turn, folds them to a quarter turn and
// converts them to radians with 30 fraction bits in four stages.
// ----------------------------------------------------------------------------
module evrot_angle (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [evrot_pkg::ANGLE_W-1:0]   angle [0:2],
  input  evrot_pkg::carry_t                      carry_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [evrot_pkg::ZW-1:0]        z_out [0:2],
  output logic                                   nc_out [0:2],
  output evrot_pkg::carry_t                      carry_out
);

  logic v [1:4];
  logic rdy [1:5];

  logic signed [15:0] m1 [0:2];
  logic signed [15:0] m1_next [0:2];
  evrot_pkg::carry_t c1, c2, c3, c4;

  logic [30:0] base2 [0:2];
  logic [25:0] t2 [0:2];
  logic neg2 [0:2];
  logic nc2 [0:2];
  logic [30:0] base2_next [0:2];
  logic [25:0] t2_next [0:2];
  logic neg2_next [0:2];
  logic nc2_next [0:2];

  logic [11:0] e3 [0:2];
  logic [11:0] e3_next [0:2];
  logic [30:0] base3 [0:2];
  logic [25:0] t3 [0:2];
  logic neg3 [0:2];
  logic nc3 [0:2];

  logic signed [evrot_pkg::ZW-1:0] z4 [0:2];
  logic signed [evrot_pkg::ZW-1:0] z4_next [0:2];
  logic nc4 [0:2];

  always_comb begin
    rdy[5] = out_ready;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[4];
  assign carry_out = c4;

  always_comb begin
    logic signed [15:0] f;
    logic [13:0] af;
    logic [47:0] prod;
    logic [25:0] r;
    logic [31:0] q;
    for (int l = 0; l < 3; l++) begin
      if (angle[l] > 54000) begin
        m1_next[l] = 16'(angle[l] - 72000);
      end else if (angle[l] > evrot_pkg::HALF_TURN) begin
        m1_next[l] = 16'(angle[l] - evrot_pkg::TURN);
      end else if (angle[l] > -evrot_pkg::HALF_TURN) begin
        m1_next[l] = 16'(angle[l]);
      end else if (angle[l] > -54000) begin
        m1_next[l] = 16'(angle[l] + evrot_pkg::TURN);
      end else begin
        m1_next[l] = 16'(angle[l] + 72000);
      end

      nc2_next[l] = 1'b0;
      f = m1[l];
      if (m1[l] > evrot_pkg::QUARTER_TURN) begin
        f = 16'(evrot_pkg::HALF_TURN - m1[l]);
        nc2_next[l] = 1'b1;
      end else if (m1[l] < -evrot_pkg::QUARTER_TURN) begin
        f = 16'(-evrot_pkg::HALF_TURN - m1[l]);
        nc2_next[l] = 1'b1;
      end
      neg2_next[l] = f[15];
      af = f[15] ? 14'(-f) : 14'(f);
      base2_next[l] = 31'(32'(af) * 32'(evrot_pkg::RAD_INT));
      t2_next[l] = 26'(32'(af) * 32'(evrot_pkg::RAD_REM));

      prod = 48'(t2[l]) * 48'(evrot_pkg::RECIP);
      e3_next[l] = 12'(prod >> evrot_pkg::RECIP_SHIFT);

      r = t3[l] - 26'(26'(e3[l]) * 26'(evrot_pkg::HALF_TURN));
      q = 32'(base3[l]) + 32'(e3[l]) +
          ((r >= 26'(evrot_pkg::HALF_TURN)) ? 32'd1 : 32'd0);
      z4_next[l] = neg3[l] ? -evrot_pkg::ZW'(q) : evrot_pkg::ZW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 4; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m1 <= m1_next;
      c1 <= carry_in;
    end
    if (rdy[2]) begin
      base2 <= base2_next;
      t2    <= t2_next;
      neg2  <= neg2_next;
      nc2   <= nc2_next;
      c2    <= c1;
    end
    if (rdy[3]) begin
      e3    <= e3_next;
      base3 <= base2;
      t3    <= t2;
      neg3  <= neg2;
      nc3   <= nc2;
      c3    <= c2;
    end
    if (rdy[4]) begin
      z4  <= z4_next;
      nc4 <= nc3;
      c4  <= c3;
    end
  end

  assign z_out  = z4;
  assign nc_out = nc4;

endmodule

// ===== rtl/evrot_cordic.sv =====
// ----------------------------------------------------------------------------
// evrot_cordic
// Three-lane rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module evrot_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [evrot_pkg::ZW-1:0]   z_in [0:2],
  input  logic                              nc_in [0:2],
  input  evrot_pkg::carry_t                 carry_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [evrot_pkg::ZW-1:0]   x_out [0:2],
  output logic signed [evrot_pkg::ZW-1:0]   y_out [0:2],
  output logic                              nc_out [0:2],
  output evrot_pkg::carry_t                 carry_out
);

  localparam int N = (CORDIC_STAGES > evrot_pkg::ATAN_ENTRIES) ?
                     evrot_pkg::ATAN_ENTRIES : CORDIC_STAGES;

  logic v [0:N];
  logic rdy [1:N+1];
  logic signed [evrot_pkg::ZW-1:0] x [0:N][0:2];
  logic signed [evrot_pkg::ZW-1:0] y [0:N][0:2];
  logic signed [evrot_pkg::ZW-1:0] z [0:N][0:2];
  logic nc [0:N][0:2];
  evrot_pkg::carry_t cy [0:N];

  assign v[0]     = in_valid;
  assign cy[0]    = carry_in;
  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      x[0][l]  = evrot_pkg::CORDIC_GAIN;
      y[0][l]  = '0;
      z[0][l]  = z_in[l];
      nc[0][l] = nc_in[l];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [evrot_pkg::ZW-1:0] ATAN = evrot_pkg::atan_q30(k);

    assign rdy[k+1] = !v[k+1] || rdy[k+2];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k+1]) begin
        cy[k+1] <= cy[k];
        for (int l = 0; l < 3; l++) begin
          nc[k+1][l] <= nc[k][l];
          if (!z[k][l][evrot_pkg::ZW-1]) begin
            x[k+1][l] <= x[k][l] - (y[k][l] >>> k);
            y[k+1][l] <= y[k][l] + (x[k][l] >>> k);
            z[k+1][l] <= z[k][l] - ATAN;
          end else begin
            x[k+1][l] <= x[k][l] + (y[k][l] >>> k);
            y[k+1][l] <= y[k][l] - (x[k][l] >>> k);
            z[k+1][l] <= z[k][l] + ATAN;
          end
        end
      end
    end
  end

  assign out_valid = v[N];
  assign x_out     = x[N];
  assign y_out     = y[N];
  assign nc_out    = nc[N];
  assign carry_out = cy[N];

endmodule

// ===== rtl/evrot_matrix.sv =====
// ----------------------------------------------------------------------------
// evrot_matrix
// Rounds the CORDIC outputs to sine and cosine, builds the ZYX rotation
// matrix and applies it to the field vector in six stages.
// ----------------------------------------------------------------------------
module evrot_matrix #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [evrot_pkg::ZW-1:0]      x_in [0:2],
  input  logic signed [evrot_pkg::ZW-1:0]      y_in [0:2],
  input  logic                                 nc_in [0:2],
  input  evrot_pkg::carry_t                    carry_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [evrot_pkg::FIELD_W-1:0] o_out [0:2],
  output evrot_pkg::carry_t                    carry_out
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int TW = F + 2;
  localparam int RW = F + 3;
  localparam int PW = RW + evrot_pkg::FIELD_W;
  localparam int AW = PW + 2;
  localparam int SH = 30 - F;

  localparam logic signed [evrot_pkg::ZW:0] ONE  = (evrot_pkg::ZW+1)'(1) <<< F;
  localparam logic signed [evrot_pkg::ZW:0] HALF = (evrot_pkg::ZW+1)'(1) <<< (SH - 1);
  localparam logic signed [AW-1:0] ARND = AW'(1) <<< (F - 1);
  localparam logic signed [AW-1:0] OMAX = AW'(evrot_pkg::SAT_MAX);
  localparam logic signed [AW-1:0] OMIN = AW'(evrot_pkg::SAT_MIN);

  function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) <<< (F - 1));
    return TW'(p >>> F);
  endfunction

  function automatic logic signed [TW-1:0] trig(input logic signed [evrot_pkg::ZW-1:0] v);
    logic signed [evrot_pkg::ZW:0] r;
    r = ((evrot_pkg::ZW+1)'(v) + HALF) >>> SH;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return TW'(r);
  endfunction

  logic v [1:6];
  logic rdy [1:7];

  logic signed [TW-1:0] cs1 [0:2];
  logic signed [TW-1:0] sn1 [0:2];
  // Lanes: roll, pitch, heading.
  // p: ch*cp, ch*sp, sh*cr, sh*sp, ch*cr, sh*sr, ch*sr, cp*sr, cp*cr, sh*cp.
  logic signed [TW-1:0] p2 [0:9];
  logic signed [TW-1:0] sr2, cr2, sp2;
  // q: ch*sp*sr, ch*sp*cr, sh*sp*sr, sh*sp*cr.
  logic signed [TW-1:0] q3 [0:3];
  logic signed [TW-1:0] p3 [0:9];
  logic signed [TW-1:0] sp3;
  logic signed [RW-1:0] r4 [0:8];
  logic signed [PW-1:0] pr5 [0:8];
  logic signed [evrot_pkg::FIELD_W-1:0] o6 [0:2];
  logic signed [evrot_pkg::FIELD_W-1:0] o6_next [0:2];
  evrot_pkg::carry_t c1, c2, c3, c4, c5, c6;

  always_comb begin
    rdy[7] = out_ready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[6];
  assign o_out     = o6;
  assign carry_out = c6;

  always_comb begin
    logic signed [AW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = AW'(pr5[3*i]) + AW'(pr5[3*i+1]) + AW'(pr5[3*i+2]) + ARND;
      acc = acc >>> F;
      if (acc > OMAX) acc = OMAX;
      if (acc < OMIN) acc = OMIN;
      o6_next[i] = evrot_pkg::FIELD_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 6; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        cs1[l] <= nc_in[l] ? -trig(x_in[l]) : trig(x_in[l]);
        sn1[l] <= trig(y_in[l]);
      end
      c1 <= carry_in;
    end
    if (rdy[2]) begin
      p2[0] <= fmul(cs1[2], cs1[1]);
      p2[1] <= fmul(cs1[2], sn1[1]);
      p2[2] <= fmul(sn1[2], cs1[0]);
      p2[3] <= fmul(sn1[2], sn1[1]);
      p2[4] <= fmul(cs1[2], cs1[0]);
      p2[5] <= fmul(sn1[2], sn1[0]);
      p2[6] <= fmul(cs1[2], sn1[0]);
      p2[7] <= fmul(cs1[1], sn1[0]);
      p2[8] <= fmul(cs1[1], cs1[0]);
      p2[9] <= fmul(sn1[2], cs1[1]);
      sr2 <= sn1[0];
      cr2 <= cs1[0];
      sp2 <= sn1[1];
      c2  <= c1;
    end
    if (rdy[3]) begin
      q3[0] <= fmul(p2[1], sr2);
      q3[1] <= fmul(p2[1], cr2);
      q3[2] <= fmul(p2[3], sr2);
      q3[3] <= fmul(p2[3], cr2);
      p3  <= p2;
      sp3 <= sp2;
      c3  <= c2;
    end
    if (rdy[4]) begin
      r4[0] <= RW'(p3[0]);
      r4[1] <= RW'(q3[0]) - RW'(p3[2]);
      r4[2] <= RW'(q3[1]) + RW'(p3[5]);
      r4[3] <= RW'(p3[9]);
      r4[4] <= RW'(q3[2]) + RW'(p3[4]);
      r4[5] <= RW'(q3[3]) - RW'(p3[6]);
      r4[6] <= -RW'(sp3);
      r4[7] <= RW'(p3[7]);
      r4[8] <= RW'(p3[8]);
      c4 <= c3;
    end
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        pr5[3*i]   <= PW'(r4[3*i])   * PW'(c4.bx);
        pr5[3*i+1] <= PW'(r4[3*i+1]) * PW'(c4.by);
        pr5[3*i+2] <= PW'(r4[3*i+2]) * PW'(c4.bz);
      end
      c5 <= c4;
    end
    if (rdy[6]) begin
      o6 <= o6_next;
      c6 <= c5;
    end
  end

endmodule

// ===== rtl/evrot_isqrt.sv =====
// ----------------------------------------------------------------------------
// evrot_isqrt
// Squares the rotated components, sums them and takes the integer square
// root one result bit per stage; selects rotated or pass-through data at the output.
// ----------------------------------------------------------------------------
module evrot_isqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [evrot_pkg::FIELD_W-1:0] o_in [0:2],
  input  evrot_pkg::carry_t                    carry_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [evrot_pkg::FIELD_W-1:0] field_x_out,
  output logic signed [evrot_pkg::FIELD_W-1:0] field_y_out,
  output logic signed [evrot_pkg::FIELD_W-1:0] field_z_out,
  output logic        [evrot_pkg::FIELD_W-1:0] magnitude_out,
  output logic                                 rotated
);

  localparam int STEPS = 24;
  localparam int LAST  = STEPS + 2;

  logic v [1:LAST];
  logic rdy [1:LAST+1];
  logic [46:0] sq1 [0:2];
  logic signed [evrot_pkg::FIELD_W-1:0] o1 [0:2];
  logic signed [evrot_pkg::FIELD_W-1:0] o [2:LAST][0:2];
  logic [47:0] rem [2:LAST];
  logic [47:0] res [2:LAST];
  evrot_pkg::carry_t c1;
  evrot_pkg::carry_t cy [2:LAST];

  always_comb begin
    rdy[LAST+1] = out_ready;
    for (int k = LAST; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= LAST; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < 3; l++) begin
        sq1[l] <= 47'(48'(o_in[l]) * 48'(o_in[l]));
      end
      o1 <= o_in;
      c1 <= carry_in;
    end
    if (rdy[2]) begin
      rem[2] <= 48'(sq1[0]) + 48'(sq1[1]) + 48'(sq1[2]);
      res[2] <= '0;
      o[2]   <= o1;
      cy[2]  <= c1;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [47:0] BIT = 48'(1) << (46 - 2 * k);
    logic [47:0] trial;
    assign trial = res[k+2] + BIT;

    always_ff @(posedge clk) begin
      if (rdy[k+3]) begin
        o[k+3]  <= o[k+2];
        cy[k+3] <= cy[k+2];
        if (rem[k+2] >= trial) begin
          rem[k+3] <= rem[k+2] - trial;
          res[k+3] <= (res[k+2] >> 1) + BIT;
        end else begin
          rem[k+3] <= rem[k+2];
          res[k+3] <= res[k+2] >> 1;
        end
      end
    end
  end

  always_comb begin
    rotated = cy[LAST].orient;
    if (cy[LAST].orient) begin
      field_x_out   = o[LAST][0];
      field_y_out   = o[LAST][1];
      field_z_out   = o[LAST][2];
      magnitude_out = res[LAST][evrot_pkg::FIELD_W-1:0];
    end else begin
      field_x_out   = cy[LAST].bx;
      field_y_out   = cy[LAST].by;
      field_z_out   = cy[LAST].bz;
      magnitude_out = cy[LAST].mag;
    end
  end

endmodule

// ===== rtl/euler_zyx_vector_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotation_unit
// Rotates a three-axis magnetic vector into the level frame with the
// rotation Rz(heading) * Ry(pitch) * Rx(roll) and recomputes its magnitude.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata                                  tuser
// s_       in         roll, pitch, heading, x, y, z, mag     orient_valid
// m_       out        x, y, z, mag                           rotated
//
// One item per cycle is accepted unless the output stalls; the pipeline depth
// is set by the CORDIC iterations and the 24 square root steps.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it moves, so bubbles close up under a stall and nothing is lost.
// Reset clears all valid bits.
// ----------------------------------------------------------------------------
module euler_zyx_vector_rotation_unit #(
  parameter int CORDIC_STAGES  = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // roll_angle, pitch_angle, heading_angle, field_x_in, field_y_in,
  // field_z_in, magnitude_in, zero fill
  input  logic [151:0] s_tdata,
  // orient_valid
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // field_x_out, field_y_out, field_z_out, magnitude_out
  output logic [95:0]  m_tdata,
  // rotated
  output logic         m_tuser
);

  logic signed [evrot_pkg::ANGLE_W-1:0] angle [0:2];
  evrot_pkg::carry_t carry_in, carry_a, carry_c, carry_m;

  logic a_valid, a_ready, c_valid, c_ready, m_valid, m_ready;
  logic signed [evrot_pkg::ZW-1:0] z_a [0:2];
  logic nc_a [0:2];
  logic signed [evrot_pkg::ZW-1:0] x_c [0:2];
  logic signed [evrot_pkg::ZW-1:0] y_c [0:2];
  logic nc_c [0:2];
  logic signed [evrot_pkg::FIELD_W-1:0] o_m [0:2];
  logic signed [evrot_pkg::FIELD_W-1:0] field_x_out, field_y_out, field_z_out;
  logic [evrot_pkg::FIELD_W-1:0] magnitude_out;

  assign angle[0] = s_tdata[16:0];
  assign angle[1] = s_tdata[33:17];
  assign angle[2] = s_tdata[50:34];
  assign carry_in.orient = s_tuser;
  assign carry_in.bx     = s_tdata[74:51];
  assign carry_in.by     = s_tdata[98:75];
  assign carry_in.bz     = s_tdata[122:99];
  assign carry_in.mag    = s_tdata[146:123];

  evrot_angle u_angle (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .angle(angle), .carry_in(carry_in),
    .out_valid(a_valid), .out_ready(a_ready),
    .z_out(z_a), .nc_out(nc_a), .carry_out(carry_a)
  );

  evrot_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst(rst),
    .in_valid(a_valid), .in_ready(a_ready),
    .z_in(z_a), .nc_in(nc_a), .carry_in(carry_a),
    .out_valid(c_valid), .out_ready(c_ready),
    .x_out(x_c), .y_out(y_c), .nc_out(nc_c), .carry_out(carry_c)
  );

  evrot_matrix #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst),
    .in_valid(c_valid), .in_ready(c_ready),
    .x_in(x_c), .y_in(y_c), .nc_in(nc_c), .carry_in(carry_c),
    .out_valid(m_valid), .out_ready(m_ready),
    .o_out(o_m), .carry_out(carry_m)
  );

  evrot_isqrt u_isqrt (
    .clk(clk), .rst(rst),
    .in_valid(m_valid), .in_ready(m_ready),
    .o_in(o_m), .carry_in(carry_m),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .field_x_out(field_x_out), .field_y_out(field_y_out),
    .field_z_out(field_z_out), .magnitude_out(magnitude_out),
    .rotated(m_tuser)
  );

  assign m_tdata = {magnitude_out, field_z_out, field_y_out, field_x_out};

  // A blocked input means the whole pipeline is full and the output stalled.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input blocked while the output is not stalled");

  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  // A rotated zero vector must have a zero magnitude.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (m_tdata[71:0] == 72'd0)) |-> (m_tdata[95:72] == 24'd0))
    else $error("magnitude not aligned with its components");

endmodule
